[hdl/rdc_pkg.sv]
`default_nettype none
package rdc_pkg;
    localparam int PRIME_BITS_DEF = 16;
    localparam int CFG_WIDTH = 16;
    localparam int CT_WIDTH = 32;
    localparam logic [CFG_WIDTH-1:0] P_RESET = 16'd167;
    localparam logic [CFG_WIDTH-1:0] Q_RESET = 16'd151;
    localparam logic CFG_IDX_P = 1'b0;
    localparam logic CFG_IDX_Q = 1'b1;
    localparam int ROOT_LIMIT = 128;
endpackage
`default_nettype wire

[hdl/rdc_if.sv]
`default_nettype none
interface rdc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] ciphertext;
    modport source (output valid, output ciphertext, input ready);
    modport sink (input valid, input ciphertext, output ready);
endinterface

interface rdc_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] plaintext;
    logic       found;
    logic [1:0] root_index;
    modport source (output valid, output plaintext, output found, output root_index,
                    input ready);
    modport sink (input valid, input plaintext, input found, input root_index,
                  output ready);
endinterface

interface rdc_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hdl/rabin_decrypt_crt_core.sv]
`default_nettype none
// Rabin decryption core with CRT recombination.
// Channels: cfg writes prime_p (index 0) and prime_q (index 1), keeping the low
// PRIME_BITS bits, at most 16; in takes one ciphertext word; out returns one
// result word with plaintext, found and root_index.
// One shared shift-and-add modular multiplier does every modular product
// and the reduction of the ciphertext; separate logic reduces the CRT sums.
// The extended Euclid runs on a restoring divider that takes one quotient
// bit per cycle.
// Latency is data dependent: each exponentiation takes one reduction of the
// ciphertext plus up to 15 squarings and 14 multiplies, Euclid takes up to
// about 25 steps, and the recombination takes 4 calls. Small primes need far
// fewer squarings, multiplies and Euclid steps.
// The core accepts one word at a time; in.ready is low while it works and
// while a result waits in the output register.
// A stalled receiver holds the result word; nothing is lost.
// Reset restores prime_p = 167, prime_q = 151 and empties the core.
module rabin_decrypt_crt_core #(
    parameter int PRIME_BITS = rdc_pkg::PRIME_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    rdc_cfg_if.sink  cfg,
    rdc_in_if.sink   in,
    rdc_out_if.source out
);
    localparam int W = 32;
    localparam int SW = 34;
    localparam int PB = (PRIME_BITS > 16) ? 16 : PRIME_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_PRED, S_PREDW, S_EXPSQ, S_EXPMUL, S_EXPW, S_EXPSW, S_EUC,
        S_DIV, S_EUCUPD, S_TA1, S_TA1W, S_TA2, S_TA2W, S_TB1, S_TB1W,
        S_TB2, S_TB2W, S_SEL, S_OUT
    } state_t;

    state_t state_reg;
    logic [15:0] p_reg, q_reg;
    logic [W-1:0] c_reg, n_reg, mp_reg, mq_reg, base_reg, acc_reg, ta_reg;
    logic [15:0] e_reg;
    logic side_reg;
    logic sq_reg;
    logic signed [SW-1:0] ea_reg, eb_reg, x0_reg, x1_reg, y0_reg, y1_reg;
    logic [16:0] dq_reg, dr_reg;
    logic [4:0] dcnt_reg;
    logic mm_start;
    logic [W-1:0] mm_a, mm_b, mm_m, mm_res;
    logic mm_done;
    logic [6:0] pt_reg;
    logic found_reg;
    logic [1:0] idx_reg;
    logic [W-1:0] mcur;
    logic [W:0] rsum, ssum;
    logic [W-1:0] rr, ss;
    logic [17:0] dtrial;
    logic [16:0] ea_low;
    logic dbit;
    logic signed [SW-1:0] xp, yq;
    logic [W-1:0] xpm, yqm;

    rdc_modmul #(.W(W)) u_mm (
        .clk(clk), .rst_n(rst_n), .start(mm_start), .a(mm_a), .b(mm_b),
        .m(mm_m), .done(mm_done), .result(mm_res)
    );

    assign cfg.ready = 1'b1;
    assign in.ready = (state_reg == S_IDLE);
    assign out.valid = (state_reg == S_OUT);
    assign out.plaintext = pt_reg;
    assign out.found = found_reg;
    assign out.root_index = idx_reg;

    assign mcur = side_reg ? {16'd0, q_reg} : {16'd0, p_reg};
    assign ea_low = ea_reg[16:0];
    assign dbit = ea_low[5'd16 - dcnt_reg];
    assign dtrial = {dr_reg, dbit} - {1'b0, eb_reg[16:0]};
    // The magnitude of each coefficient goes through the shared unit, and the
    // product is negated modulo n when the coefficient is negative.
    assign xp = x0_reg;
    assign yq = y0_reg;
    assign xpm = xp[SW-1] ? W'(-xp) : W'(xp);
    assign yqm = yq[SW-1] ? W'(-yq) : W'(yq);
    assign rsum = {1'b0, ta_reg} + {1'b0, acc_reg};
    assign rr = (rsum >= {1'b0, n_reg}) ? W'(rsum - {1'b0, n_reg}) : rsum[W-1:0];
    assign ssum = {1'b0, ta_reg} + {1'b0, n_reg} - {1'b0, acc_reg};
    assign ss = (ssum >= {1'b0, n_reg}) ? W'(ssum - {1'b0, n_reg}) : ssum[W-1:0];

    always_comb
    begin
        mm_start = 1'b0;
        mm_a = '0;
        mm_b = '0;
        mm_m = mcur;
        unique case (state_reg)
            S_PRED:
            begin
                mm_start = 1'b1;
                mm_a = W'(1);
                mm_b = c_reg;
            end
            S_EXPSQ:
            begin
                mm_start = 1'b1;
                mm_a = base_reg;
                mm_b = base_reg;
            end
            S_EXPMUL:
            begin
                mm_start = 1'b1;
                mm_a = acc_reg;
                mm_b = base_reg;
            end
            S_TA1:
            begin
                mm_start = 1'b1;
                mm_a = xpm;
                mm_b = {16'd0, p_reg};
                mm_m = n_reg;
            end
            S_TA2:
            begin
                mm_start = 1'b1;
                mm_a = ta_reg;
                mm_b = mq_reg;
                mm_m = n_reg;
            end
            S_TB1:
            begin
                mm_start = 1'b1;
                mm_a = yqm;
                mm_b = {16'd0, q_reg};
                mm_m = n_reg;
            end
            S_TB2:
            begin
                mm_start = 1'b1;
                mm_a = acc_reg;
                mm_b = mp_reg;
                mm_m = n_reg;
            end
            default:
            begin
                mm_m = mcur;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            p_reg <= rdc_pkg::P_RESET;
            q_reg <= rdc_pkg::Q_RESET;
            found_reg <= 1'b0;
            pt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == rdc_pkg::CFG_IDX_P)
                begin
                    p_reg <= 16'(cfg.data[PB-1:0]);
                end
                else
                begin
                    q_reg <= 16'(cfg.data[PB-1:0]);
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in.valid)
                    begin
                        c_reg <= in.ciphertext;
                        n_reg <= W'(p_reg) * W'(q_reg);
                        side_reg <= 1'b0;
                        found_reg <= 1'b0;
                        pt_reg <= '0;
                        idx_reg <= '0;
                        if (p_reg == 16'd0 || q_reg == 16'd0)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_PRED;
                        end
                    end
                end
                S_PRED:
                begin
                    e_reg <= 16'((17'(mcur[15:0]) + 17'd1) >> 2);
                    acc_reg <= W'(1);
                    state_reg <= S_PREDW;
                end
                S_PREDW:
                begin
                    if (mm_done)
                    begin
                        base_reg <= mm_res;
                        state_reg <= S_EXPW;
                    end
                end
                S_EXPW:
                begin
                    if (e_reg == 16'd0)
                    begin
                        if (!side_reg)
                        begin
                            mp_reg <= acc_reg;
                            side_reg <= 1'b1;
                            state_reg <= S_PRED;
                        end
                        else
                        begin
                            mq_reg <= acc_reg;
                            ea_reg <= SW'(p_reg);
                            eb_reg <= SW'(q_reg);
                            x0_reg <= SW'(1);
                            x1_reg <= '0;
                            y0_reg <= '0;
                            y1_reg <= SW'(1);
                            state_reg <= S_EUC;
                        end
                    end
                    else if (e_reg[0])
                    begin
                        sq_reg <= 1'b0;
                        state_reg <= S_EXPMUL;
                    end
                    else
                    begin
                        sq_reg <= 1'b1;
                        state_reg <= S_EXPSQ;
                    end
                end
                S_EXPMUL, S_EXPSQ:
                begin
                    state_reg <= S_EXPSW;
                end
                S_EXPSW:
                begin
                    if (mm_done)
                    begin
                        if (!sq_reg)
                        begin
                            acc_reg <= mm_res;
                            sq_reg <= 1'b1;
                            state_reg <= S_EXPSQ;
                        end
                        else
                        begin
                            base_reg <= mm_res;
                            e_reg <= e_reg >> 1;
                            state_reg <= S_EXPW;
                        end
                    end
                end
                S_EUC:
                begin
                    if (eb_reg == '0)
                    begin
                        state_reg <= S_TA1;
                    end
                    else
                    begin
                        dq_reg <= '0;
                        dr_reg <= '0;
                        dcnt_reg <= 5'd0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (!dtrial[17])
                    begin
                        dr_reg <= dtrial[16:0];
                        dq_reg <= {dq_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        dr_reg <= {dr_reg[15:0], dbit};
                        dq_reg <= {dq_reg[15:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'd16)
                    begin
                        state_reg <= S_EUCUPD;
                    end
                end
                S_EUCUPD:
                begin
                    ea_reg <= eb_reg;
                    eb_reg <= SW'(dr_reg);
                    x0_reg <= x1_reg;
                    x1_reg <= x0_reg - SW'($signed({1'b0, dq_reg}) * x1_reg);
                    y0_reg <= y1_reg;
                    y1_reg <= y0_reg - SW'($signed({1'b0, dq_reg}) * y1_reg);
                    state_reg <= S_EUC;
                end
                S_TA1:
                begin
                    state_reg <= S_TA1W;
                end
                S_TA1W:
                begin
                    if (mm_done)
                    begin
                        ta_reg <= (xp[SW-1] && mm_res != '0) ? n_reg - mm_res : mm_res;
                        state_reg <= S_TA2;
                    end
                end
                S_TA2:
                begin
                    state_reg <= S_TA2W;
                end
                S_TA2W:
                begin
                    if (mm_done)
                    begin
                        ta_reg <= mm_res;
                        state_reg <= S_TB1;
                    end
                end
                S_TB1:
                begin
                    state_reg <= S_TB1W;
                end
                S_TB1W:
                begin
                    if (mm_done)
                    begin
                        acc_reg <= (yq[SW-1] && mm_res != '0) ? n_reg - mm_res : mm_res;
                        state_reg <= S_TB2;
                    end
                end
                S_TB2:
                begin
                    state_reg <= S_TB2W;
                end
                S_TB2W:
                begin
                    if (mm_done)
                    begin
                        acc_reg <= mm_res;
                        state_reg <= S_SEL;
                    end
                end
                S_SEL:
                begin
                    state_reg <= S_OUT;
                    priority if (rr < W'(rdc_pkg::ROOT_LIMIT))
                    begin
                        found_reg <= 1'b1;
                        pt_reg <= rr[6:0];
                        idx_reg <= 2'd0;
                    end
                    else if (n_reg - rr < W'(rdc_pkg::ROOT_LIMIT))
                    begin
                        found_reg <= 1'b1;
                        pt_reg <= 7'(n_reg - rr);
                        idx_reg <= 2'd1;
                    end
                    else if (ss < W'(rdc_pkg::ROOT_LIMIT))
                    begin
                        found_reg <= 1'b1;
                        pt_reg <= ss[6:0];
                        idx_reg <= 2'd2;
                    end
                    else if (n_reg - ss < W'(rdc_pkg::ROOT_LIMIT))
                    begin
                        found_reg <= 1'b1;
                        pt_reg <= 7'(n_reg - ss);
                        idx_reg <= 2'd3;
                    end
                end
                S_OUT:
                begin
                    if (out.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[hdl/rdc_modmul.sv]
`default_nettype none
// Computes (a * b) mod m by shift-and-add, one bit of b per cycle.
module rdc_modmul #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic [W-1:0] m,
    output logic              done,
    output logic [W-1:0]      result
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0] acc_reg, aa_reg, b_reg, m_reg;
    logic [CW-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;
    logic [W:0] dbl, sum;
    logic [W-1:0] acc2;

    always_comb
    begin
        dbl = {acc_reg, 1'b0};
        if (dbl >= {1'b0, m_reg})
        begin
            dbl = dbl - {1'b0, m_reg};
        end
        acc2 = dbl[W-1:0];
        sum = {1'b0, acc2} + (b_reg[W-1] ? {1'b0, aa_reg} : '0);
        if (sum >= {1'b0, m_reg})
        begin
            sum = sum - {1'b0, m_reg};
        end
    end

    assign result = acc_reg;
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
            acc_reg <= '0;
            aa_reg <= '0;
            b_reg <= '0;
            m_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(W);
                acc_reg <= '0;
                aa_reg <= (a >= m) ? a - m : a;
                b_reg <= b;
                m_reg <= m;
            end
            else if (busy_reg)
            begin
                acc_reg <= sum[W-1:0];
                b_reg <= {b_reg[W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

[verif/rabin_decrypt_crt_core_test.sv]
`timescale 1ns / 100ps
`default_nettype none
module rabin_decrypt_crt_core_test;
    typedef struct packed {
        logic [6:0] plaintext;
        logic       found;
        logic [1:0] root_index;
    } decrypt_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rdc_cfg_if cfg_ch();
    rdc_in_if in_ch();
    rdc_out_if out_ch();

    rabin_decrypt_crt_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_ch.sink),
        .in(in_ch.sink),
        .out(out_ch.source)
    );

    always #2 clk = ~clk;

    longint unsigned key_p = rdc_pkg::P_RESET;
    longint unsigned key_q = rdc_pkg::Q_RESET;
    decrypt_word_t expected_words[$];
    int unsigned mismatch_count = 0;
    int unsigned words_sent = 0;
    int unsigned words_checked = 0;
    int unsigned found_count = 0;
    longint unsigned cycle_count = 0;
    bit idle_enabled = 1'b1;
    int unsigned hold_off_cycles = 0;
    int unsigned out_idle_left = 0;

    function automatic longint unsigned mod_power(longint unsigned base,
            longint unsigned expo, longint unsigned modulus);
        longint unsigned acc;
        longint unsigned b;
        acc = 1;
        b = base % modulus;
        while (expo != 0)
        begin
            if (expo[0])
                acc = (acc * b) % modulus;
            b = (b * b) % modulus;
            expo = expo >> 1;
        end
        return acc;
    endfunction

    function automatic decrypt_word_t decrypt_value(longint unsigned cipher);
        decrypt_word_t w;
        longint unsigned n, mp, mq, ta, tb, r, s, ap, aq;
        longint a, b, quo, rem, x0, x1, y0, y1, t;
        longint unsigned roots[4];
        w = '0;
        if (key_p == 0 || key_q == 0)
            return w;
        n = key_p * key_q;
        mp = mod_power(cipher, (key_p + 1) >> 2, key_p);
        mq = mod_power(cipher, (key_q + 1) >> 2, key_q);
        a = key_p;
        b = key_q;
        x0 = 1; x1 = 0; y0 = 0; y1 = 1;
        while (b != 0)
        begin
            quo = a / b;
            rem = a % b;
            a = b;
            b = rem;
            t = x0 - quo * x1; x0 = x1; x1 = t;
            t = y0 - quo * y1; y0 = y1; y1 = t;
        end
        t = x0 % longint'(n);
        if (t < 0)
            t += longint'(n);
        ap = t;
        t = y0 % longint'(n);
        if (t < 0)
            t += longint'(n);
        aq = t;
        ta = (((ap * key_p) % n) * mq) % n;
        tb = (((aq * key_q) % n) * mp) % n;
        r = (ta + tb) % n;
        s = (ta + n - tb) % n;
        roots[0] = r;
        roots[1] = n - r;
        roots[2] = s;
        roots[3] = n - s;
        for (int i = 0; i < 4; i++)
        begin
            if (roots[i] < rdc_pkg::ROOT_LIMIT)
            begin
                w.plaintext = roots[i][6:0];
                w.found = 1'b1;
                w.root_index = i[1:0];
                return w;
            end
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
            input int unsigned want);
        $display("mismatch on word %0d: %s got %0d expected %0d", words_checked, what, got,
            want);
        mismatch_count++;
    endtask

    task automatic random_gap();
        int unsigned gap;
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_cipher(input logic [31:0] cipher);
        random_gap();
        in_ch.valid <= 1'b1;
        in_ch.ciphertext <= cipher;
        expected_words.insert(expected_words.size(), decrypt_value(cipher));
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic write_key(input logic index, input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (index == rdc_pkg::CFG_IDX_P)
            key_p = value;
        else
            key_q = value;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_keys(input logic [15:0] p, input logic [15:0] q);
        wait_drained();
        write_key(rdc_pkg::CFG_IDX_P, p);
        write_key(rdc_pkg::CFG_IDX_Q, q);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_below_modulus();
        longint unsigned n;
        n = key_p * key_q;
        if (n == 0 || $urandom_range(0, 9) == 0)
            return $urandom();
        return 32'($urandom() % n);
    endfunction

    task automatic test_reset_keys();
        send_cipher(32'd0);
        send_cipher(32'd1);
        send_cipher(32'd4);
        send_cipher(32'hFFFF_FFFF);
        send_cipher(32'd25217);
        send_cipher(32'd25216);
        for (int m = 0; m < 6; m++)
            send_cipher(32'(m * m * 37 % 128 * (m + 1)));
    endtask

    task automatic test_odd_keys();
        set_keys(16'd3, 16'd7);
        send_cipher(32'd2);
        send_cipher(32'd20);
        send_cipher(32'hAAAA_AAAA);
        set_keys(16'd0, 16'd151);
        send_cipher(32'd9);
        set_keys(16'd167, 16'd0);
        send_cipher(32'd9);
        set_keys(16'd1, 16'd2);
        send_cipher(32'd5);
        set_keys(16'd12, 16'd8);
        send_cipher(32'd99);
        set_keys(16'd151, 16'd167);
        send_cipher(32'd16);
        set_keys(16'hFFFF, 16'hFFFB);
        send_cipher(32'd49);
        send_cipher(32'h5555_5555);
    endtask

    task automatic test_random_keys();
        logic [15:0] small_primes [8] = '{16'd3, 16'd7, 16'd11, 16'd19, 16'd23, 16'd131,
            16'd167, 16'd151};
        logic [15:0] big_primes [4] = '{16'd65519, 16'd65071, 16'd32771, 16'd40499};
        int unsigned m;
        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase % 4 == 3)
                set_keys(big_primes[$urandom_range(0, 3)], big_primes[$urandom_range(0, 3)]);
            else if (phase == 5)
                set_keys(16'($urandom()), 16'($urandom()));
            else
                set_keys(small_primes[$urandom_range(0, 7)],
                    small_primes[$urandom_range(0, 7)]);
            for (int k = 0; k < 24; k++)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    m = $urandom_range(0, 127);
                    send_cipher(32'((longint'(m) * m) %
                        (key_p * key_q == 0 ? 1 : key_p * key_q)));
                end
                else
                    send_cipher(random_below_modulus());
            end
        end
    endtask

    task automatic test_output_stall();
        hold_off_cycles = 6000;
        for (int k = 0; k < 4; k++)
            send_cipher(random_below_modulus());
    endtask

    task automatic test_no_idle();
        wait_drained();
        idle_enabled = 1'b0;
        set_keys(16'd167, 16'd151);
        for (int k = 0; k < 30; k++)
            send_cipher(random_below_modulus());
    endtask

    always @(posedge clk)
    begin
        if (hold_off_cycles != 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else if (out_idle_left != 0)
        begin
            out_idle_left <= out_idle_left - 1;
            out_ch.ready <= (out_idle_left == 1);
        end
        else if (idle_enabled && $urandom_range(0, 15) == 0)
        begin
            out_idle_left <= $urandom_range(1, 16);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        decrypt_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected result word", 1, 0);
            else
            begin
                want = expected_words.pop_front();
                if (out_ch.plaintext !== want.plaintext)
                    report_mismatch("plaintext", out_ch.plaintext, want.plaintext);
                if (out_ch.found !== want.found)
                    report_mismatch("found", out_ch.found, want.found);
                if (out_ch.root_index !== want.root_index)
                    report_mismatch("root_index", out_ch.root_index, want.root_index);
                if (want.found)
                    found_count++;
                words_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3_000_000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.ciphertext = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = rdc_pkg::CFG_IDX_P;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_keys();
        test_odd_keys();
        test_random_keys();
        test_output_stall();
        test_no_idle();
        wait_drained();
        repeat (3000) @(posedge clk);
        $display("Sent %0d ciphertext words and checked %0d results, %0d with a root found.",
            words_sent, words_checked, found_count);
        $display("Covered reset, degenerate, random and large prime pairs with stalls.");
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
